// ===== hdl/mtd_pkg.sv =====
// mtd_pkg: shared types and constants of the morse trie decoder
// sequencer states, request codes, character codes and the result record
// no dependencies
package mtd_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_LINE_END,
		ST_LOAD
	} mtd_state_t;

	localparam logic MODE_DECODE = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;

	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_DASH   = 8'h2D;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_PERIOD = 8'h2E;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// request field layout on s_tdata
	localparam int SYM_LSB = 0;
	localparam int LEN_LSB = 8;
	localparam int PAT_LSB = 11;
	localparam int IN_DATA_W = 24;

	typedef struct packed {
		logic [7:0] out_char;
		logic       line_last;
		logic       bad_code;
	} mtd_result_t;

endpackage

// ===== hdl/morse_trie_decoder_core.sv =====
// morse_trie_decoder_core: morse decoder over a heap-indexed code trie
// holds the trie tables, the decode sequencer and a four-entry result queue
// depends on mtd_pkg

// A decode request reads the tables, then evaluates the registered reads,
// and when it ends a line it goes on to a line-end step, since the character
// of the node reached must be read from the character table. A load request
// marks the prefix nodes of its code, one per dot or dash, one per cycle
// through the single write port of the presence table. After reset the block
// runs a clearing pass over both tables and accepts no request until it is
// done. Results go through a four-entry queue, so a new request is taken
// while earlier results wait, as long as the queue has room for two.
module morse_trie_decoder_core #(
	parameter int MAX_CODE_LENGTH = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] symbol_byte, [10:8] code_length, [16:11] code_pattern, [23:17] zero
	input  logic [23:0] s_tdata,
	input  logic        s_tlast,   // line_end
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_char
	output logic [7:0]  m_tdata,
	output logic        m_tlast,   // line_last
	output logic        m_tuser    // bad_code
);
	import mtd_pkg::*;

	localparam int NW = MAX_CODE_LENGTH + 1;
	localparam int TRIE_SIZE = 1 << NW;
	localparam logic [NW-1:0] ROOT = NW'(1);
	localparam logic [3:0] MAX_LEN = 4'(MAX_CODE_LENGTH);

	mtd_state_t state_q, state_d;

	logic [7:0] char_mem [TRIE_SIZE];
	logic       pres_mem [TRIE_SIZE];

	logic [NW-1:0] cur_q;
	logic [15:0]   last_two_q;
	logic          line_empty_q;
	logic          letter_just_q;

	logic [7:0]    byte_q;
	logic          lend_q;
	logic [7:0]    sym_q;
	logic [7:0]    pat_q;
	logic [2:0]    pos_q;
	logic [NW-1:0] idx_q;
	logic [NW-1:0] clr_q;

	logic [7:0] char_rd_q;
	logic       pres_rd_q;

	// result queue
	mtd_result_t fifo_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  cnt_q;

	logic        accept;
	logic [7:0]  in_byte;
	logic [2:0]  in_len;
	logic [5:0]  in_pat;

	logic [NW-1:0] char_addr;
	logic [NW-1:0] pres_addr;
	logic          char_we, pres_we;
	logic [NW-1:0] char_waddr, pres_waddr;
	logic [7:0]    char_wdata;
	logic          pres_wdata;

	logic          push;
	mtd_result_t   push_item;
	logic          pop;

	logic          dec_move, dec_dash, dec_ok, dec_ls, dec_keep, dec_letter;
	logic [NW:0]   dec_child;
	logic [7:0]    dec_char;
	logic [NW-1:0] new_node;
	logic          in_dash;
	logic [NW:0]   in_child;
	logic          ld_bit;
	logic [NW-1:0] ld_idx;

	assign in_byte = s_tdata[SYM_LSB +: 8];
	assign in_len  = s_tdata[LEN_LSB +: 3];
	assign in_pat  = s_tdata[PAT_LSB +: 6];

	assign s_tready = (state_q == ST_IDLE) && (cnt_q <= 3'd2);
	assign accept   = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = fifo_q[rd_ptr_q].out_char;
	assign m_tlast  = fifo_q[rd_ptr_q].line_last;
	assign m_tuser  = fifo_q[rd_ptr_q].bad_code;

	// child of the current node for the incoming byte
	assign in_dash  = (in_byte == CHAR_DASH);
	assign in_child = {cur_q, in_dash};

	// evaluation of a decode request from the registered table reads
	assign dec_dash  = (byte_q == CHAR_DASH);
	assign dec_move  = dec_dash || (byte_q == CHAR_DOT);
	assign dec_child = {cur_q, dec_dash};
	assign dec_ok    = !dec_child[NW] && pres_rd_q;
	assign dec_ls    = letter_just_q && (byte_q == CHAR_SPACE);
	assign dec_letter = !dec_move && (char_rd_q != CHAR_SPACE);
	assign dec_keep  = line_empty_q ||
		((last_two_q[7:0] == CHAR_SPACE) && (last_two_q[15:8] == CHAR_PERIOD));
	always_comb begin
		dec_char = char_rd_q;
		if (!dec_keep && (char_rd_q >= CHAR_UPPER_A) && (char_rd_q <= CHAR_UPPER_Z)) begin
			dec_char = char_rd_q + CASE_OFFSET;
		end
	end
	always_comb begin
		new_node = cur_q;
		if (dec_move) begin
			new_node = dec_ok ? dec_child[NW-1:0] : ROOT;
		end else if (dec_letter) begin
			new_node = ROOT;
		end
	end

	// load walk: one heap level per cycle, first symbol at bit pos_q
	assign ld_bit = pat_q[pos_q];
	generate
		if (NW > 1) begin : g_idx
			assign ld_idx = {idx_q[NW-2:0], ld_bit};
		end else begin : g_idx1
			assign ld_idx = ld_bit;
		end
	endgenerate

	always_comb begin
		state_d    = state_q;
		char_addr  = cur_q;
		pres_addr  = in_child[NW-1:0];
		char_we    = 1'b0;
		pres_we    = 1'b0;
		char_waddr = clr_q;
		pres_waddr = clr_q;
		char_wdata = CHAR_SPACE;
		pres_wdata = 1'b0;
		push       = 1'b0;
		push_item  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				char_we    = 1'b1;
				pres_we    = 1'b1;
				pres_wdata = (clr_q == ROOT);
				if (clr_q == NW'(TRIE_SIZE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == MODE_DECODE) begin
						state_d = ST_DECODE;
					end else if ((in_len != 3'd0) && ({1'b0, in_len} <= MAX_LEN)) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_DECODE: begin
				char_addr = new_node;
				// a pending late space implies the walk sits at the root, whose
				// character is a space, so it never meets a second result here
				if (dec_ls) begin
					push      = 1'b1;
					push_item = '{out_char: CHAR_SPACE, line_last: 1'b0, bad_code: 1'b0};
				end else if (dec_move && !dec_ok) begin
					push      = 1'b1;
					push_item = '{out_char: 8'd0, line_last: 1'b0, bad_code: 1'b1};
				end else if (dec_letter) begin
					push      = 1'b1;
					push_item = '{out_char: dec_char, line_last: 1'b0, bad_code: 1'b0};
				end
				state_d = lend_q ? ST_LINE_END : ST_IDLE;
			end
			ST_LINE_END: begin
				push      = 1'b1;
				push_item = '{out_char: char_rd_q, line_last: 1'b1, bad_code: 1'b0};
				state_d   = ST_IDLE;
			end
			ST_LOAD: begin
				pres_we    = 1'b1;
				pres_waddr = ld_idx;
				pres_wdata = 1'b1;
				if (pos_q == 3'd0) begin
					char_we    = 1'b1;
					char_waddr = ld_idx;
					char_wdata = sym_q;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// trie tables
	always_ff @(posedge clk) begin
		if (char_we) begin
			char_mem[char_waddr] <= char_wdata;
		end
		char_rd_q <= char_mem[char_addr];
	end

	always_ff @(posedge clk) begin
		if (pres_we) begin
			pres_mem[pres_waddr] <= pres_wdata;
		end
		pres_rd_q <= pres_mem[pres_addr];
	end

	// request capture and load walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
			lend_q <= s_tlast;
			sym_q  <= in_byte;
			pat_q  <= {2'b00, in_pat};
			pos_q  <= in_len - 3'd1;
			idx_q  <= ROOT;
		end else if (state_q == ST_LOAD) begin
			pos_q <= pos_q - 3'd1;
			idx_q <= ld_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + NW'(1);
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q         <= ROOT;
			last_two_q    <= '0;
			line_empty_q  <= 1'b1;
			letter_just_q <= 1'b0;
		end else if (state_q == ST_DECODE) begin
			cur_q         <= new_node;
			letter_just_q <= !dec_ls && dec_letter;
			if (dec_ls) begin
				last_two_q   <= {last_two_q[7:0], CHAR_SPACE};
				line_empty_q <= 1'b0;
			end else if (dec_letter) begin
				last_two_q   <= {last_two_q[7:0], dec_char};
				line_empty_q <= 1'b0;
			end
		end else if (state_q == ST_LINE_END) begin
			cur_q         <= ROOT;
			last_two_q    <= '0;
			line_empty_q  <= 1'b1;
			letter_just_q <= 1'b0;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== hdl/mtd_checker.sv =====
// mtd_checker: port-level checks of morse_trie_decoder_core over time
// bound to the top level below; depends on mtd_pkg
module mtd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);
	import mtd_pkg::*;

	// a decode request takes the sequencer out of the idle state, so the request after it is held off
	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_DECODE) |=> !s_tready)
		else $error("request taken right after a decode request");

	// an error result carries no character and never closes a line
	a_bad_code_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 8'd0) && !m_tlast)
		else $error("malformed error result");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	// a decode request that ends a line leads to a valid result after its decode and line-end steps
	a_line_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_DECODE) && s_tlast |=> ##2 m_tvalid)
		else $error("no result after line end");

endmodule

bind morse_trie_decoder_core mtd_checker u_mtd_checker (.*);
